// ===== rtl/core/dimg_pkg.sv =====
// shared types, constants and helpers for the depth image to grid map block
package dimg_pkg;

  localparam int MAX_IMAGE_COLS = 1024;
  localparam int MAX_IMAGE_ROWS = 512;
  localparam int GRID_SIDE      = 64;

  localparam int NCELLS  = GRID_SIDE * GRID_SIDE;
  localparam int GRID_W  = $clog2(GRID_SIDE);
  localparam int CELL_W  = $clog2(NCELLS);
  localparam int SLOT_W  = $clog2(NCELLS + 1);
  localparam int PT_RAW  = MAX_IMAGE_COLS * MAX_IMAGE_ROWS;
  localparam int PT_LIMIT = (PT_RAW > 524288) ? 524288 : PT_RAW;

  localparam int OSLOT_W = 20;
  localparam int CNT_W   = 20;
  localparam int COORD_W = 24;
  localparam int DEPTH_W = 16;
  localparam int SUM_W   = 48;
  localparam int DVD_W   = 48;
  localparam int DVS_W   = 20;
  localparam int DIV_CW  = $clog2(DVD_W);

  localparam int CFG_AW  = 5;
  localparam int CFG_DW  = 32;

  localparam logic [2:0] REG_FOCAL = 3'd0;
  localparam logic [2:0] REG_CAM_H = 3'd1;
  localparam logic [2:0] REG_IMG_W = 3'd2;
  localparam logic [2:0] REG_IMG_H = 3'd3;
  localparam logic [2:0] REG_MAP_W = 3'd4;
  localparam logic [2:0] REG_MAP_H = 3'd5;
  localparam logic [2:0] REG_CELL  = 3'd6;

  typedef enum logic [1:0] {
    OP_PIXEL = 2'd0,
    OP_READ  = 2'd1,
    OP_FRAME = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [4:0] {
    ST_BOOT_CLR,
    ST_IDLE,
    ST_FRAME_CLR,
    ST_PIX,
    ST_DIV_H,
    ST_DIV_X,
    ST_CHECK,
    ST_DIV_GX,
    ST_DIV_GY,
    ST_GRID,
    ST_UPD,
    ST_CELL_RD,
    ST_CELL_CHK,
    ST_DIV_AX,
    ST_DIV_AF,
    ST_DIV_AH,
    ST_CELL_OUT
  } state_t;

  typedef enum logic [2:0] {
    DV_H,
    DV_X,
    DV_GX,
    DV_GY,
    DV_AX,
    DV_AF,
    DV_AH
  } div_sel_t;

  typedef enum logic [1:0] {
    OK_NULL,
    OK_PIXEL,
    OK_CELL
  } out_kind_t;

  typedef struct packed {
    logic [11:0] focal;
    logic [11:0] cam_h;
    logic [10:0] img_w;
    logic [9:0]  img_h;
    logic [15:0] map_w;
    logic [15:0] map_h;
    logic [15:0] cell_sz;
  } cfg_t;

  typedef struct packed {
    logic                    vld;
    logic [SLOT_W-1:0]       slot;
    logic [CNT_W-1:0]        cnt;
    logic signed [SUM_W-1:0] sx;
    logic signed [SUM_W-1:0] sf;
    logic signed [SUM_W-1:0] sh;
  } cell_t;

  typedef struct packed {
    logic      accept;
    logic      clr_init;
    logic      clr_step;
    logic      div_go;
    div_sel_t  div_sel;
    logic      div_cap;
    logic      upd;
    logic      out_load;
    out_kind_t out_kind;
  } cmd_t;

  typedef struct packed {
    logic z_zero;
    logic clr_last;
    logic div_done;
    logic pix_in;
    logic grid_ok;
    logic cell_ok;
  } sts_t;

  function automatic logic signed [COORD_W-1:0] sat24(input logic signed [49:0] v);
    logic signed [49:0] hi;
    logic signed [49:0] lo;
    hi = 50'sd8388607;
    lo = -50'sd8388608;
    if (v > hi) begin
      return hi[COORD_W-1:0];
    end else if (v < lo) begin
      return lo[COORD_W-1:0];
    end else begin
      return v[COORD_W-1:0];
    end
  endfunction

endpackage

// ===== rtl/core/dimg_ram.sv =====
// generic single-write, registered-read memory
module dimg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/dimg_div.sv =====
// shared restoring divider, one quotient bit per cycle
module dimg_div
  import dimg_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             go,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic [DVD_W-1:0] quo,
  output logic             done
);

  logic [DVS_W-1:0]  rem_r;
  logic [DVS_W-1:0]  rem_nxt;
  logic [DVD_W-1:0]  quo_r;
  logic [DVD_W-1:0]  quo_nxt;
  logic [DVS_W-1:0]  dvs_r;
  logic [DIV_CW-1:0] cnt_r;
  logic              run_r;
  logic              done_r;
  logic [DVS_W:0]    sh;
  logic [DVS_W+1:0]  trial;

  always_comb begin
    sh    = {rem_r, quo_r[DVD_W-1]};
    trial = {1'b0, sh} - {2'b0, dvs_r};
    if (!trial[DVS_W+1]) begin
      rem_nxt = trial[DVS_W-1:0];
      quo_nxt = {quo_r[DVD_W-2:0], 1'b1};
    end else begin
      rem_nxt = sh[DVS_W-1:0];
      quo_nxt = {quo_r[DVD_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CW'(DVD_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (run_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quo  = quo_r;
  assign done = done_r;

endmodule

// ===== rtl/core/dimg_dp.sv =====
// datapath: projection arithmetic, grid memory, counters and result registers
module dimg_dp
  import dimg_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  cfg_t                      cfg,
  input  cmd_t                      cmd,
  output sts_t                      sts,
  input  logic [8:0]                in_row,
  input  logic [9:0]                in_col,
  input  logic [DEPTH_W-1:0]        in_depth_mm,
  input  logic [5:0]                in_cell_x,
  input  logic [5:0]                in_cell_y,
  output logic                      out_valid,
  output logic signed [OSLOT_W-1:0] out_slot,
  output logic [CNT_W-1:0]          out_point_count,
  output logic signed [COORD_W-1:0] out_x_mm,
  output logic [DEPTH_W-1:0]        out_forward_mm,
  output logic signed [COORD_W-1:0] out_height_mm
);

  logic [8:0]                row_r;
  logic [9:0]                col_r;
  logic [DEPTH_W-1:0]        z_r;
  logic [GRID_W-1:0]         gx_r;
  logic [GRID_W-1:0]         gy_r;
  logic                      gx_ok_r;
  logic                      gy_ok_r;
  logic signed [COORD_W-1:0] x_r;
  logic signed [COORD_W-1:0] h_r;
  logic [OSLOT_W-1:0]        nps_r;
  logic [SLOT_W-1:0]         ncs_r;
  logic [CELL_W-1:0]         clr_r;
  div_sel_t                  div_sel_r;
  logic                      neg_r;

  logic                      out_valid_r;
  logic signed [OSLOT_W-1:0] out_slot_r;
  logic [CNT_W-1:0]          out_cnt_r;
  logic signed [COORD_W-1:0] out_x_r;
  logic [DEPTH_W-1:0]        out_f_r;
  logic signed [COORD_W-1:0] out_h_r;

  logic signed [12:0] dh;
  logic signed [12:0] dx;
  logic signed [16:0] zs;
  logic signed [29:0] ph;
  logic signed [29:0] px;
  logic [29:0]        ph_mag;
  logic [29:0]        px_mag;
  logic [12:0]        f2;
  logic [16:0]        cell2;
  logic signed [26:0] mx2;
  logic signed [18:0] my2;
  logic [16:0]        mw2;
  logic [16:0]        mh2;

  logic [DVD_W-1:0]   dvd;
  logic [DVS_W-1:0]   dvs;
  logic               dneg;
  logic [DVD_W-1:0]   quo;
  logic               div_done;
  logic signed [48:0] qs;
  logic signed [49:0] cam50;

  logic [CELL_W-1:0]  idx;
  logic [CELL_W-1:0]  waddr;
  cell_t              ent;
  cell_t              nent;
  cell_t              wdata;
  logic               we;
  logic [$bits(cell_t)-1:0] rdata;

  assign ent = cell_t'(rdata);

  // products and map position from the latched pixel
  always_comb begin
    dh     = $signed({3'd0, cfg.img_h}) - $signed({3'd0, row_r, 1'b0});
    dx     = $signed({2'd0, col_r, 1'b0}) - $signed({2'd0, cfg.img_w});
    zs     = $signed({1'b0, z_r});
    ph     = dh * zs;
    px     = dx * zs;
    ph_mag = ph[29] ? 30'(-ph) : 30'(ph);
    px_mag = px[29] ? 30'(-px) : 30'(px);
    f2     = {(cfg.focal == '0) ? 12'd1 : cfg.focal, 1'b0};
    cell2  = {(cfg.cell_sz == '0) ? 16'd1 : cfg.cell_sz, 1'b0};
    mx2    = $signed({11'd0, cfg.map_w}) + $signed({{2{x_r[COORD_W-1]}}, x_r, 1'b0});
    my2    = $signed({3'd0, cfg.map_h}) - $signed({2'd0, z_r, 1'b0});
    mw2    = {cfg.map_w, 1'b0};
    mh2    = {cfg.map_h, 1'b0};
  end

  // divider operands
  always_comb begin
    dvd  = '0;
    dvs  = '0;
    dneg = 1'b0;
    case (cmd.div_sel)
      DV_H: begin
        dvd  = DVD_W'(ph_mag);
        dvs  = DVS_W'(f2);
        dneg = ph[29];
      end
      DV_X: begin
        dvd  = DVD_W'(px_mag);
        dvs  = DVS_W'(f2);
        dneg = !px[29];
      end
      DV_GX: begin
        dvd = DVD_W'(mx2[25:0]);
        dvs = DVS_W'(cell2);
      end
      DV_GY: begin
        dvd = DVD_W'(my2[17:0]);
        dvs = DVS_W'(cell2);
      end
      DV_AX: begin
        dvd  = ent.sx[SUM_W-1] ? DVD_W'(-ent.sx) : DVD_W'(ent.sx);
        dvs  = ent.cnt;
        dneg = ent.sx[SUM_W-1];
      end
      DV_AF: begin
        dvd = DVD_W'(ent.sf);
        dvs = ent.cnt;
      end
      DV_AH: begin
        dvd  = ent.sh[SUM_W-1] ? DVD_W'(-ent.sh) : DVD_W'(ent.sh);
        dvs  = ent.cnt;
        dneg = ent.sh[SUM_W-1];
      end
      default: begin
        dvd = '0;
      end
    endcase
  end

  dimg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (cmd.div_go),
    .dividend (dvd),
    .divisor  (dvs),
    .quo      (quo),
    .done     (div_done)
  );

  assign qs    = neg_r ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
  assign cam50 = $signed({38'd0, cfg.cam_h});

  // cell update
  always_comb begin
    nent      = ent;
    nent.vld  = 1'b1;
    nent.slot = ent.vld ? ent.slot : ncs_r;
    nent.cnt  = ent.cnt + 1'b1;
    nent.sx   = ent.sx + SUM_W'(x_r);
    nent.sf   = ent.sf + $signed({32'd0, z_r});
    nent.sh   = ent.sh + SUM_W'(h_r);
  end

  assign idx   = CELL_W'(gy_r) * CELL_W'(GRID_SIDE) + CELL_W'(gx_r);
  assign we    = cmd.clr_step | cmd.upd;
  assign waddr = cmd.clr_step ? clr_r : idx;
  assign wdata = cmd.clr_step ? '0 : nent;

  dimg_ram #(
    .WIDTH ($bits(cell_t)),
    .DEPTH (NCELLS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (idx),
    .rdata (rdata)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nps_r       <= '0;
      ncs_r       <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.out_load;
      if (cmd.clr_init) begin
        nps_r <= '0;
        ncs_r <= '0;
        clr_r <= '0;
      end else begin
        if (cmd.clr_step) begin
          clr_r <= clr_r + 1'b1;
        end
        if (cmd.upd) begin
          nps_r <= nps_r + 1'b1;
          if (!ent.vld) begin
            ncs_r <= ncs_r + 1'b1;
          end
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      row_r   <= in_row;
      col_r   <= in_col;
      z_r     <= in_depth_mm;
      gx_r    <= GRID_W'(in_cell_x);
      gy_r    <= GRID_W'(in_cell_y);
      gx_ok_r <= (int'(in_cell_x) < GRID_SIDE);
      gy_ok_r <= (int'(in_cell_y) < GRID_SIDE);
    end
    if (cmd.div_go) begin
      div_sel_r <= cmd.div_sel;
      neg_r     <= dneg;
    end
    if (cmd.div_cap) begin
      case (div_sel_r)
        DV_H:  h_r <= sat24(50'(qs) + cam50);
        DV_X:  x_r <= sat24(50'(qs));
        DV_GX: begin
          gx_ok_r <= (quo < DVD_W'(GRID_SIDE));
          gx_r    <= quo[GRID_W-1:0];
        end
        DV_GY: begin
          gy_ok_r <= (quo < DVD_W'(GRID_SIDE));
          gy_r    <= quo[GRID_W-1:0];
        end
        DV_AX: x_r <= qs[COORD_W-1:0];
        DV_AF: z_r <= quo[DEPTH_W-1:0];
        DV_AH: h_r <= qs[COORD_W-1:0];
        default: begin
          x_r <= x_r;
        end
      endcase
    end
    if (cmd.out_load) begin
      case (cmd.out_kind)
        OK_PIXEL: begin
          out_slot_r <= $signed(nps_r);
          out_cnt_r  <= '0;
          out_x_r    <= x_r;
          out_f_r    <= z_r;
          out_h_r    <= h_r;
        end
        OK_CELL: begin
          out_slot_r <= $signed(OSLOT_W'(ent.slot));
          out_cnt_r  <= ent.cnt;
          out_x_r    <= x_r;
          out_f_r    <= z_r;
          out_h_r    <= h_r;
        end
        default: begin
          out_slot_r <= '1;
          out_cnt_r  <= '0;
          out_x_r    <= '0;
          out_f_r    <= '0;
          out_h_r    <= '0;
        end
      endcase
    end
  end

  always_comb begin
    sts.z_zero   = (z_r == '0);
    sts.clr_last = (clr_r == CELL_W'(NCELLS - 1));
    sts.div_done = div_done;
    sts.pix_in   = (h_r > 0) && !mx2[26] && (mx2 < $signed({10'd0, mw2}))
                   && !my2[18] && (my2 < $signed({2'd0, mh2}));
    sts.grid_ok  = gx_ok_r && gy_ok_r && (nps_r < OSLOT_W'(PT_LIMIT));
    sts.cell_ok  = gx_ok_r && gy_ok_r && ent.vld && (ent.cnt != '0);
  end

  assign out_valid       = out_valid_r;
  assign out_slot        = out_slot_r;
  assign out_point_count = out_cnt_r;
  assign out_x_mm        = out_x_r;
  assign out_forward_mm  = out_f_r;
  assign out_height_mm   = out_h_r;

endmodule

// ===== rtl/core/dimg_ctrl.sv =====
// controller state machine sequencing the datapath
module dimg_ctrl
  import dimg_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] in_op,
  input  sts_t       sts,
  output cmd_t       cmd,
  output logic       busy
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_BOOT_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.div_sel  = DV_H;
    cmd.out_kind = OK_NULL;
    case (state_r)
      ST_BOOT_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          case (op_t'(in_op))
            OP_PIXEL: state_nxt = ST_PIX;
            OP_READ:  state_nxt = ST_CELL_RD;
            OP_FRAME: begin
              cmd.clr_init = 1'b1;
              state_nxt    = ST_FRAME_CLR;
            end
            default: begin
              cmd.out_load = 1'b1;
            end
          endcase
        end
      end
      ST_FRAME_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_PIX: begin
        if (sts.z_zero) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end else begin
          cmd.div_go  = 1'b1;
          cmd.div_sel = DV_H;
          state_nxt   = ST_DIV_H;
        end
      end
      ST_DIV_H: begin
        if (sts.div_done) begin
          cmd.div_cap = 1'b1;
          cmd.div_go  = 1'b1;
          cmd.div_sel = DV_X;
          state_nxt   = ST_DIV_X;
        end
      end
      ST_DIV_X: begin
        if (sts.div_done) begin
          cmd.div_cap = 1'b1;
          state_nxt   = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!sts.pix_in) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end else begin
          cmd.div_go  = 1'b1;
          cmd.div_sel = DV_GX;
          state_nxt   = ST_DIV_GX;
        end
      end
      ST_DIV_GX: begin
        if (sts.div_done) begin
          cmd.div_cap = 1'b1;
          cmd.div_go  = 1'b1;
          cmd.div_sel = DV_GY;
          state_nxt   = ST_DIV_GY;
        end
      end
      ST_DIV_GY: begin
        if (sts.div_done) begin
          cmd.div_cap = 1'b1;
          state_nxt   = ST_GRID;
        end
      end
      ST_GRID: begin
        if (!sts.grid_ok) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end else begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        cmd.upd      = 1'b1;
        cmd.out_load = 1'b1;
        cmd.out_kind = OK_PIXEL;
        state_nxt    = ST_IDLE;
      end
      ST_CELL_RD: begin
        state_nxt = ST_CELL_CHK;
      end
      ST_CELL_CHK: begin
        if (!sts.cell_ok) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end else begin
          cmd.div_go  = 1'b1;
          cmd.div_sel = DV_AX;
          state_nxt   = ST_DIV_AX;
        end
      end
      ST_DIV_AX: begin
        if (sts.div_done) begin
          cmd.div_cap = 1'b1;
          cmd.div_go  = 1'b1;
          cmd.div_sel = DV_AF;
          state_nxt   = ST_DIV_AF;
        end
      end
      ST_DIV_AF: begin
        if (sts.div_done) begin
          cmd.div_cap = 1'b1;
          cmd.div_go  = 1'b1;
          cmd.div_sel = DV_AH;
          state_nxt   = ST_DIV_AH;
        end
      end
      ST_DIV_AH: begin
        if (sts.div_done) begin
          cmd.div_cap = 1'b1;
          state_nxt   = ST_CELL_OUT;
        end
      end
      ST_CELL_OUT: begin
        cmd.out_load = 1'b1;
        cmd.out_kind = OK_CELL;
        state_nxt    = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule

// ===== rtl/core/depth_image_to_grid_map.sv =====
// top level: configuration registers, controller and datapath
//
// Depth pixels are back-projected and binned into a GRID_SIDE x GRID_SIDE map, one
// transaction at a time: a transaction is taken when start is high and busy is low,
// and its single result appears on the out_ ports for one cycle with out_valid high;
// the receiver cannot stall, so results must be taken as they come.
// All divisions share one restoring divider that yields one quotient bit per cycle,
// so a pixel takes up to four divisions (none if it is rejected for zero depth), a
// cell read three divisions, and an unused op code is answered without busy going
// high. A frame start, and likewise the period after reset, sweeps the grid memory
// one cell per cycle with busy high; configuration writes are taken at any time but
// belong in idle periods.
module depth_image_to_grid_map
  import dimg_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                in_op,
  input  logic [8:0]                in_row,
  input  logic [9:0]                in_col,
  input  logic [DEPTH_W-1:0]        in_depth_mm,
  input  logic [5:0]                in_cell_x,
  input  logic [5:0]                in_cell_y,
  output logic                      out_valid,
  output logic signed [OSLOT_W-1:0] out_slot,
  output logic [CNT_W-1:0]          out_point_count,
  output logic signed [COORD_W-1:0] out_x_mm,
  output logic [DEPTH_W-1:0]        out_forward_mm,
  output logic signed [COORD_W-1:0] out_height_mm,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [CFG_AW-1:0]         paddr,
  input  logic [CFG_DW-1:0]         pwdata,
  output logic [CFG_DW-1:0]         prdata,
  output logic                      pready
);

  cfg_t       cfg_r;
  cmd_t       cmd;
  sts_t       sts;
  logic       cfg_wr;
  logic [2:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[CFG_AW-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.focal   <= 12'd400;
      cfg_r.cam_h   <= 12'd0;
      cfg_r.img_w   <= 11'd752;
      cfg_r.img_h   <= 10'd480;
      cfg_r.map_w   <= 16'd3200;
      cfg_r.map_h   <= 16'd3200;
      cfg_r.cell_sz <= 16'd50;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_FOCAL: cfg_r.focal   <= pwdata[11:0];
        REG_CAM_H: cfg_r.cam_h   <= pwdata[11:0];
        REG_IMG_W: cfg_r.img_w   <= pwdata[10:0];
        REG_IMG_H: cfg_r.img_h   <= pwdata[9:0];
        REG_MAP_W: cfg_r.map_w   <= pwdata[15:0];
        REG_MAP_H: cfg_r.map_h   <= pwdata[15:0];
        REG_CELL:  cfg_r.cell_sz <= pwdata[15:0];
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_FOCAL: prdata = CFG_DW'(cfg_r.focal);
      REG_CAM_H: prdata = CFG_DW'(cfg_r.cam_h);
      REG_IMG_W: prdata = CFG_DW'(cfg_r.img_w);
      REG_IMG_H: prdata = CFG_DW'(cfg_r.img_h);
      REG_MAP_W: prdata = CFG_DW'(cfg_r.map_w);
      REG_MAP_H: prdata = CFG_DW'(cfg_r.map_h);
      REG_CELL:  prdata = CFG_DW'(cfg_r.cell_sz);
      default:   prdata = '0;
    endcase
  end

  dimg_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .in_op (in_op),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  dimg_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .cmd             (cmd),
    .sts             (sts),
    .in_row          (in_row),
    .in_col          (in_col),
    .in_depth_mm     (in_depth_mm),
    .in_cell_x       (in_cell_x),
    .in_cell_y       (in_cell_y),
    .out_valid       (out_valid),
    .out_slot        (out_slot),
    .out_point_count (out_point_count),
    .out_x_mm        (out_x_mm),
    .out_forward_mm  (out_forward_mm),
    .out_height_mm   (out_height_mm)
  );

`ifndef NO_ASSERTIONS
  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while a transaction is still in progress");

  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted transaction neither in progress nor answered");

  a_reject_no_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_slot == '1) |-> (out_point_count == '0 && out_x_mm == '0))
    else $error("empty result carries data");
`endif

endmodule
